[hw/rtl/lmpp_pkg.sv]
// ----------------------------------------------------------------------------
// lmpp_pkg
// Shared types and default sizes for the local maximum peak picker.
// ----------------------------------------------------------------------------
package lmpp_pkg;

  localparam int POS_WIDTH_DEF    = 32;
  localparam int HEIGHT_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF  = 16;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // input transfer happens this cycle
    logic div_step;  // advance the divider by one quotient bit
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;      // the offered sample closes a peak
    logic div_last;  // the divider is on its final bit
  } dp_status_t;

endpackage

[hw/rtl/lmpp_if.sv]
// ----------------------------------------------------------------------------
// lmpp_in_if / lmpp_out_if
// Valid/ready channels for samples and for peaks.
// ----------------------------------------------------------------------------
interface lmpp_in_if #(
  parameter int POS_WIDTH    = lmpp_pkg::POS_WIDTH_DEF,
  parameter int HEIGHT_WIDTH = lmpp_pkg::HEIGHT_WIDTH_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [POS_WIDTH-1:0]    x;
  logic [HEIGHT_WIDTH-1:0] y;
  logic                    first;
  logic                    last;

  modport source (output valid, output x, output y, output first, output last,
                  input ready);
  modport sink   (input valid, input x, input y, input first, input last,
                  output ready);
endinterface

interface lmpp_out_if #(
  parameter int POS_WIDTH    = lmpp_pkg::POS_WIDTH_DEF,
  parameter int HEIGHT_WIDTH = lmpp_pkg::HEIGHT_WIDTH_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [POS_WIDTH-1:0]    left_x;
  logic [POS_WIDTH-1:0]    right_x;
  logic [POS_WIDTH-1:0]    apex_x;
  logic [HEIGHT_WIDTH-1:0] apex_height;

  modport source (output valid, output left_x, output right_x, output apex_x,
                  output apex_height, input ready);
  modport sink   (input valid, input left_x, input right_x, input apex_x,
                  input apex_height, output ready);
endinterface

[hw/rtl/lmpp_ctrl.sv]
// ----------------------------------------------------------------------------
// lmpp_ctrl
// Controller: input handshake, divider sequencing and output valid.
// ----------------------------------------------------------------------------
module lmpp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lmpp_pkg::dp_status_t  sts,
  output lmpp_pkg::ctrl_cmd_t   cmd
);

  lmpp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmpp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      lmpp_pkg::ST_IDLE: begin
        // A sample may come in as long as the output register is free or
        // being emptied this cycle, since it may close a peak.
        in_ready = !out_valid_r || out_ready;
        cmd.take = in_valid && in_ready;
        if (cmd.take && sts.emit) begin
          state_nxt = lmpp_pkg::ST_DIV;
        end
      end
      lmpp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt     = lmpp_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/lmpp_datapath.sv]
// ----------------------------------------------------------------------------
// lmpp_datapath
// Peak tracking registers, result registers and a bit-serial divider for
// the mean apex position.
// ----------------------------------------------------------------------------
module lmpp_datapath #(
  parameter int POS_WIDTH    = lmpp_pkg::POS_WIDTH_DEF,
  parameter int HEIGHT_WIDTH = lmpp_pkg::HEIGHT_WIDTH_DEF,
  parameter int COUNT_WIDTH  = lmpp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [POS_WIDTH-1:0]    in_x,
  input  logic [HEIGHT_WIDTH-1:0] in_y,
  input  logic                    in_first,
  input  logic                    in_last,
  input  lmpp_pkg::ctrl_cmd_t     cmd,
  output lmpp_pkg::dp_status_t    sts,
  output logic [POS_WIDTH-1:0]    out_left_x,
  output logic [POS_WIDTH-1:0]    out_right_x,
  output logic [POS_WIDTH-1:0]    out_apex_x,
  output logic [HEIGHT_WIDTH-1:0] out_apex_height
);

  localparam int SUM_W = POS_WIDTH + COUNT_WIDTH;
  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0]       CNT_LAST = CNT_W'(SUM_W - 1);
  localparam logic [COUNT_WIDTH-1:0] TIE_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] TIE_ONE  = COUNT_WIDTH'(1);

  // Peak tracking state.
  logic [POS_WIDTH-1:0]    start_r, start_nxt;
  logic [POS_WIDTH-1:0]    end_r, end_nxt;
  logic                    ev_r, ev_nxt;
  logic [POS_WIDTH-1:0]    prev_pos_r, prev_pos_nxt;
  logic [HEIGHT_WIDTH-1:0] prev_h_r, prev_h_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [HEIGHT_WIDTH-1:0] level_r, level_nxt;
  logic [COUNT_WIDTH-1:0]  tie_r, tie_nxt;

  // Result and divider registers.
  logic [POS_WIDTH-1:0]    left_r, right_r;
  logic [HEIGHT_WIDTH-1:0] height_r;
  logic [SUM_W-1:0]        quo_r, quo_nxt;
  logic [COUNT_WIDTH-1:0]  rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0]  dvs_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                    tie_nz;
  logic [POS_WIDTH-1:0]    start1, end1;
  logic                    ev1;
  logic                    emit;
  logic [COUNT_WIDTH:0]    trial;
  logic [COUNT_WIDTH:0]    diff;

  always_comb begin
    tie_nz = (tie_r != '0);
    start1 = (!tie_nz && in_y <= prev_h_r) ? in_x : start_r;
    if (tie_nz && in_y < prev_h_r) begin
      end1 = in_x;
      ev1  = 1'b1;
    end else begin
      end1 = end_r;
      ev1  = ev_r;
    end
    emit = !in_first && tie_nz && ev1 && (in_y >= prev_h_r || in_last);

    start_nxt    = start1;
    end_nxt      = end1;
    ev_nxt       = ev1;
    sum_nxt      = sum_r;
    level_nxt    = level_r;
    tie_nxt      = tie_r;
    prev_pos_nxt = in_x;
    prev_h_nxt   = in_y;

    priority if (in_first) begin
      start_nxt = in_x;
      end_nxt   = '0;
      ev_nxt    = 1'b0;
      sum_nxt   = '0;
      level_nxt = '0;
      tie_nxt   = '0;
    end else if (emit) begin
      // The next peak opens at the previous sample with this one as apex.
      start_nxt = prev_pos_r;
      tie_nxt   = TIE_ONE;
      level_nxt = in_y;
      sum_nxt   = SUM_W'(in_x);
      ev_nxt    = 1'b0;
      end_nxt   = '0;
    end else if (in_y > level_r) begin
      tie_nxt   = TIE_ONE;
      level_nxt = in_y;
      sum_nxt   = SUM_W'(in_x);
      ev_nxt    = 1'b0;
      end_nxt   = '0;
    end else if (in_y == level_r) begin
      if (tie_r != TIE_MAX) begin
        sum_nxt = sum_r + SUM_W'(in_x);
        tie_nxt = tie_r + TIE_ONE;
      end
    end
  end

  // Restoring division, one quotient bit per cycle, quotient shifted in
  // place of the dividend.
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.take && emit) begin
      quo_nxt = sum_r;
      rem_nxt = '0;
      cnt_nxt = CNT_LAST;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[COUNT_WIDTH-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_WIDTH-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= '0;
      end_r      <= '0;
      ev_r       <= 1'b0;
      prev_pos_r <= '0;
      prev_h_r   <= '0;
      sum_r      <= '0;
      level_r    <= '0;
      tie_r      <= '0;
    end else if (cmd.take) begin
      start_r    <= start_nxt;
      end_r      <= end_nxt;
      ev_r       <= ev_nxt;
      prev_pos_r <= prev_pos_nxt;
      prev_h_r   <= prev_h_nxt;
      sum_r      <= sum_nxt;
      level_r    <= level_nxt;
      tie_r      <= tie_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && emit) begin
      left_r   <= start1;
      right_r  <= end1;
      height_r <= level_r;
      dvs_r    <= tie_r;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.emit        = emit;
  assign sts.div_last    = (cnt_r == '0);
  assign out_left_x      = left_r;
  assign out_right_x     = right_r;
  assign out_apex_x      = quo_r[POS_WIDTH-1:0];
  assign out_apex_height = height_r;

endmodule

[hw/rtl/local_maximum_peak_picker.sv]
// ----------------------------------------------------------------------------
// local_maximum_peak_picker
// Streams spectrum samples and reports each local-maximum peak with its
// boundaries, mean apex position and apex height.
//
//   Channel   Dir  Fields                                   Handshake
//   in_chan   in   x, y, first, last                        valid/ready
//   out_chan  out  left_x, right_x, apex_x, apex_height     valid/ready
//
// A sample that closes no peak does not hold off the input. A sample that
// closes a peak starts the bit-serial divider for the mean apex position,
// which develops a quotient of POS_WIDTH + COUNT_WIDTH bits (48 by default);
// the input is held off until the quotient is in the output register.
// Reset is synchronous and clears the tracking state to zero. A peak waiting
// on a stalled output holds off every sample, since the next one may close
// another peak; the input reopens in the cycle the waiting peak is taken.
// ----------------------------------------------------------------------------
module local_maximum_peak_picker #(
  parameter int POS_WIDTH    = lmpp_pkg::POS_WIDTH_DEF,
  parameter int HEIGHT_WIDTH = lmpp_pkg::HEIGHT_WIDTH_DEF,
  parameter int COUNT_WIDTH  = lmpp_pkg::COUNT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lmpp_in_if.sink   in_chan,
  lmpp_out_if.source out_chan
);

  lmpp_pkg::ctrl_cmd_t  cmd;
  lmpp_pkg::dp_status_t sts;

  lmpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lmpp_datapath #(
    .POS_WIDTH    (POS_WIDTH),
    .HEIGHT_WIDTH (HEIGHT_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_x            (in_chan.x),
    .in_y            (in_chan.y),
    .in_first        (in_chan.first),
    .in_last         (in_chan.last),
    .cmd             (cmd),
    .sts             (sts),
    .out_left_x      (out_chan.left_x),
    .out_right_x     (out_chan.right_x),
    .out_apex_x      (out_chan.apex_x),
    .out_apex_height (out_chan.apex_height)
  );

endmodule

[hw/rtl/lmpp_checker.sv]
// ----------------------------------------------------------------------------
// lmpp_checker
// Port-level checks for the peak picker, bound to the top level.
// ----------------------------------------------------------------------------
module lmpp_checker #(
  parameter int POS_WIDTH    = lmpp_pkg::POS_WIDTH_DEF,
  parameter int HEIGHT_WIDTH = lmpp_pkg::HEIGHT_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_first,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [POS_WIDTH-1:0]    left_x,
  input logic [POS_WIDTH-1:0]    right_x,
  input logic [POS_WIDTH-1:0]    apex_x,
  input logic [HEIGHT_WIDTH-1:0] apex_height
);

  // A new peak needs a full division, so it never shows right after a transfer.
  a_no_back_to_back_peaks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("peak presented in the cycle after an output transfer");

  // A first sample only initializes and cannot produce a peak.
  a_first_no_peak: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_first && !out_valid |=> !out_valid)
    else $error("first sample produced a peak");

  // While the division runs the input is closed.
  a_ready_low_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_ready |=> out_valid || !in_ready)
    else $error("input open while a peak is computed");

  // A stalled peak keeps its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_x) && $stable(right_x)
      && $stable(apex_x) && $stable(apex_height))
    else $error("stalled peak changed");

endmodule

bind local_maximum_peak_picker lmpp_checker #(
  .POS_WIDTH    (POS_WIDTH),
  .HEIGHT_WIDTH (HEIGHT_WIDTH)
) u_lmpp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_first    (in_chan.first),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .left_x      (out_chan.left_x),
  .right_x     (out_chan.right_x),
  .apex_x      (out_chan.apex_x),
  .apex_height (out_chan.apex_height)
);

[test/local_maximum_peak_picker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_maximum_peak_picker_tb
// Feeds spectrum samples through the peak picker and checks every reported
// peak, field by field, against a peak tracker kept inside the bench. The
// samples cover directed corner cases, a run of tied apex samples, and
// randomly shaped spectra mixed with noise. Random gaps on the sample side
// and random stalls on the peak side are applied throughout.
// ----------------------------------------------------------------------------
module local_maximum_peak_picker_tb;

  localparam int PW = lmpp_pkg::POS_WIDTH_DEF;
  localparam int HW = lmpp_pkg::HEIGHT_WIDTH_DEF;
  localparam int CW = lmpp_pkg::COUNT_WIDTH_DEF;
  localparam longint unsigned HMAX = (64'd1 << HW) - 1;
  localparam int TIE_RUN = 40;
  localparam int RANDOM_SAMPLES = 1240;
  localparam int HOLD_PERIOD = 3000;
  localparam int HOLD_LEN = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [HW-1:0] y;
    logic          first;
    logic          last;
    logic          drain_first;  // wait for all peaks before offering this one
    logic          has_peak;     // this sample closes a peak
  } sample_t;

  typedef struct packed {
    logic [PW-1:0] left_x;
    logic [PW-1:0] right_x;
    logic [PW-1:0] apex_x;
    logic [HW-1:0] apex_height;
  } peak_t;

  logic clk;
  logic rst_n;
  logic in_took;
  int   fail_count;
  bit   drain_next;
  int   peaks_owed;
  sample_t sent_s;

  sample_t samples_todo[$];
  peak_t   peaks_due[$];

  // Peak tracker state.
  logic [PW-1:0]    left_pos;
  logic [PW-1:0]    right_pos;
  logic             right_seen;
  logic [PW-1:0]    prev_x;
  logic [HW-1:0]    prev_y;
  logic [PW+CW-1:0] tie_sum;
  logic [HW-1:0]    apex_lvl;
  logic [CW-1:0]    tie_cnt;

  lmpp_in_if  in_chan ();
  lmpp_out_if out_chan ();

  local_maximum_peak_picker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("local_maximum_peak_picker_tb: FAIL");
    $finish;
  end

  // Advances the tracker by one sample; returns 1 when the sample closes a peak.
  function automatic bit pick_peak(input sample_t s, output peak_t p);
    logic [PW+CW-1:0] quo;
    bit               hit;
    hit = 1'b0;
    p = '0;
    if (s.first) begin
      left_pos = s.x;
      right_pos = '0;
      right_seen = 1'b0;
      prev_x = s.x;
      prev_y = s.y;
      tie_sum = '0;
      apex_lvl = '0;
      tie_cnt = '0;
      return 1'b0;
    end
    if (tie_cnt == 0 && s.y <= prev_y) left_pos = s.x;
    if (tie_cnt != 0 && s.y < prev_y) begin
      right_pos = s.x;
      right_seen = 1'b1;
    end
    if (tie_cnt != 0 && right_seen && (s.y >= prev_y || s.last)) begin
      quo = tie_sum / (PW+CW)'(tie_cnt);
      p.left_x = left_pos;
      p.right_x = right_pos;
      p.apex_x = quo[PW-1:0];
      p.apex_height = apex_lvl;
      hit = 1'b1;
      // The next peak opens at the previous sample.
      left_pos = prev_x;
      tie_cnt = CW'(1);
      apex_lvl = s.y;
      tie_sum = (PW+CW)'(s.x);
      right_seen = 1'b0;
      right_pos = '0;
    end else if (s.y > apex_lvl) begin
      tie_cnt = CW'(1);
      apex_lvl = s.y;
      tie_sum = (PW+CW)'(s.x);
      right_seen = 1'b0;
      right_pos = '0;
    end else if (s.y == apex_lvl) begin
      // A full tie counter ignores further tied samples.
      if (tie_cnt != '1) begin
        tie_sum = tie_sum + (PW+CW)'(s.x);
        tie_cnt = tie_cnt + 1'b1;
      end
    end
    prev_x = s.x;
    prev_y = s.y;
    return hit;
  endfunction

  task automatic queue_sample(input logic [PW-1:0] x, input logic [HW-1:0] y,
                              input logic first, input logic last);
    sample_t s;
    peak_t   p;
    s.x = x;
    s.y = y;
    s.first = first;
    s.last = last;
    s.drain_first = drain_next;
    drain_next = 1'b0;
    s.has_peak = pick_peak(s, p);
    samples_todo.push_back(s);
    if (s.has_peak) peaks_due.push_back(p);
  endtask

  function automatic longint unsigned rand_level();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 65535);
      default: return HW'($urandom);
    endcase
  endfunction

  // One spectrum of rising, flat and falling stretches with random heights.
  task automatic queue_spectrum();
    logic [PW-1:0]   pos;
    logic [PW-1:0]   step;
    longint unsigned lvl;
    longint unsigned top;
    longint unsigned low_y;
    longint unsigned room;
    longint unsigned y_end;
    int              n;
    pos = $urandom;
    step = ($urandom_range(0, 3) == 0) ? PW'($urandom) : PW'($urandom_range(1, 32'h0002_0000));
    lvl = rand_level();
    // Now and then a spectrum opens without its first flag.
    queue_sample(pos, HW'(lvl), $urandom_range(0, 7) != 0, 1'b0);
    repeat ($urandom_range(1, 6)) begin
      room = HMAX - lvl;
      top = (room == 0) ? lvl : lvl + 1 + (rand_level() % room);
      n = $urandom_range(1, 3);
      for (int j = 1; j <= n; j++) begin
        pos += step;
        queue_sample(pos, HW'(lvl + (top - lvl) * j / n), 1'b0, 1'b0);
      end
      repeat ($urandom_range(0, 3)) begin
        pos += step;
        queue_sample(pos, HW'(top), 1'b0, 1'b0);
      end
      low_y = (top == 0) ? 0 : rand_level() % top;
      n = $urandom_range(1, 3);
      for (int j = 1; j <= n; j++) begin
        pos += step;
        queue_sample(pos, HW'(top - (top - low_y) * j / n), 1'b0, 1'b0);
      end
      lvl = low_y;
    end
    case ($urandom_range(0, 2))
      0: y_end = (lvl == 0) ? 0 : rand_level() % lvl;
      1: y_end = lvl;
      default: y_end = rand_level();
    endcase
    pos += step;
    queue_sample(pos, HW'(y_end), 1'b0, 1'b1);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Acceptance is sampled at the rising edge; the driver acts on it at the
  // following falling edge.
  always @(posedge clk) begin
    in_took <= rst_n && in_chan.valid && in_chan.ready;
  end

  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else if (!(in_chan.valid && !in_took)) begin
      if (in_took) begin
        sent_s = samples_todo.pop_front();
        // Only peaks of samples already sent count toward a drain.
        if (sent_s.has_peak) peaks_owed++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (samples_todo.size() != 0 &&
                   !(samples_todo[0].drain_first && peaks_owed != 0)) begin
        in_chan.valid <= 1'b1;
        in_chan.x <= samples_todo[0].x;
        in_chan.y <= samples_todo[0].y;
        in_chan.first <= samples_todo[0].first;
        in_chan.last <= samples_todo[0].last;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  int          rx_cycle;
  int          hold_left;
  int          pat_age;
  logic [15:0] ready_pat;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      pat_age = 0;
      ready_pat = '1;
    end else begin
      rx_cycle++;
      // A long hold-off now and then lets the output back up into the input.
      if (rx_cycle % HOLD_PERIOD == 0) hold_left = HOLD_LEN;
      if (pat_age == 0) begin
        pat_age = 64;
        case ($urandom_range(0, 3))
          0: ready_pat = '1;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom | $urandom);
          default: ready_pat = 16'($urandom & $urandom);
        endcase
      end
      pat_age--;
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    peak_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (peaks_owed > 0) peaks_owed--;
      if (peaks_due.size() == 0) begin
        $display("%0t: unexpected peak, expected none, actual %h %h %h %h", $time,
                 out_chan.left_x, out_chan.right_x, out_chan.apex_x, out_chan.apex_height);
        fail_count++;
      end else begin
        want = peaks_due.pop_front();
        check_field("left_x", 64'(want.left_x), 64'(out_chan.left_x));
        check_field("right_x", 64'(want.right_x), 64'(out_chan.right_x));
        check_field("apex_x", 64'(want.apex_x), 64'(out_chan.apex_x));
        check_field("apex_height", 64'(want.apex_height), 64'(out_chan.apex_height));
      end
    end
  end

  initial begin
    int base;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.x = '0;
    in_chan.y = '0;
    in_chan.first = 1'b0;
    in_chan.last = 1'b0;
    out_chan.ready = 1'b0;
    fail_count = 0;
    drain_next = 1'b0;
    peaks_owed = 0;
    left_pos = '0;
    right_pos = '0;
    right_seen = 1'b0;
    prev_x = '0;
    prev_y = '0;
    tie_sum = '0;
    apex_lvl = '0;
    tie_cnt = '0;

    // Straight out of reset with no first sample: a tied apex, a dip, a rise.
    queue_sample(32'h0000_0010, 32'd5, 1'b0, 1'b0);
    queue_sample(32'h0000_0020, 32'd5, 1'b0, 1'b0);
    queue_sample(32'h0000_0030, 32'd2, 1'b0, 1'b0);
    queue_sample(32'h0000_0040, 32'd7, 1'b0, 1'b0);
    // First and last together only initialize.
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_sample(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // Last sample on a falling edge closes the peak.
    queue_sample(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1);
    queue_sample(32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1);
    // A sample level with the one before closes a peak, and so does a rise.
    queue_sample(32'h0000_0100, 32'h10, 1'b1, 1'b0);
    queue_sample(32'h0000_0200, 32'h10, 1'b0, 1'b0);
    queue_sample(32'h0000_0300, 32'h08, 1'b0, 1'b0);
    queue_sample(32'h0000_0400, 32'h08, 1'b0, 1'b0);
    queue_sample(32'h0000_0500, 32'h04, 1'b0, 1'b0);
    queue_sample(32'h0000_0600, 32'h06, 1'b0, 1'b1);
    queue_sample(32'h0000_0700, 32'h01, 1'b1, 1'b0);
    queue_sample(32'h0000_0800, 32'h01, 1'b0, 1'b1);

    // A long run of tied apex samples whose positions sum past the position width.
    drain_next = 1'b1;
    queue_sample(32'h0100_0000, 32'd0, 1'b1, 1'b0);
    queue_sample(32'h0200_0000, 32'd1000, 1'b0, 1'b0);
    for (int i = 0; i < TIE_RUN; i++) begin
      queue_sample(32'hF300_0000 + PW'(i) * 32'h0000_F00F, 32'd1000, 1'b0, 1'b0);
    end
    queue_sample(32'hFFF0_0000, 32'd500, 1'b0, 1'b0);
    queue_sample(32'hFFF8_0000, 32'd2000, 1'b0, 1'b0);
    queue_sample(32'hFFFC_0000, 32'd100, 1'b0, 1'b1);

    // Random spectra with some noise, paused for a full drain now and then.
    base = samples_todo.size();
    while (samples_todo.size() - base < RANDOM_SAMPLES) begin
      if ((samples_todo.size() - base) / 250 != ((samples_todo.size() - base) + 20) / 250)
        drain_next = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        queue_spectrum();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          queue_sample($urandom, HW'(rand_level()), $urandom_range(0, 15) == 0,
                       $urandom_range(0, 15) == 0);
        end
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (samples_todo.size() != 0) @(posedge clk);
    while (peaks_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && peaks_due.size() == 0) begin
      $display("local_maximum_peak_picker_tb: PASS");
    end else begin
      $display("local_maximum_peak_picker_tb: FAIL");
    end
    $finish;
  end

endmodule
